/* rtl/core/qpps_pkg.sv */
`default_nettype none

package qpps_pkg;

    // Position counter width; the reported position is its low 32 bits.
    localparam int POS_WIDTH = 32;
    localparam int TARGET_W  = 32;
    localparam int OUT_POS_W = 32;

    // Error spans target minus position without wrap.
    localparam int ERR_W  = ((POS_WIDTH > TARGET_W) ? POS_WIDTH : TARGET_W) + 1;
    // Change of error, gain products and their sum.
    localparam int DERR_W = ERR_W + 1;
    localparam int PTERM_W = ERR_W + 9;
    localparam int DTERM_W = DERR_W + 9;
    localparam int RESP_W  = DTERM_W + 1;

    localparam int DUTY_W = 8;
    localparam int GAIN_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam int DUTY_MAX = 255;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(4);
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(13);

    typedef enum logic [1:0] {
        REQ_ENCODER = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_TARGET  = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_DERIV_GAIN = 2'd1,
        CFG_PROP_ONLY  = 2'd2
    } cfg_index_t;

    // One decoder step: next phase and the counter move it causes.
    typedef struct packed {
        logic [1:0] phase;
        logic       cnt_up;
        logic       cnt_down;
    } quad_step_t;

    typedef struct packed {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
    } duty_t;

endpackage

`default_nettype wire

/* rtl/core/quadrature_pd_position_servo.sv */
`default_nettype none

// Quadrature-decoded PD position servo.
//
// Input stream (s_*): one word per request. s_tuser carries the request
// kind (encoder pin change, control tick, set target, clear position).
// s_tdata carries the encoder pins and the new target.
// Output stream (m_*): exactly one word per request, holding forward and
// reverse duty and the position after that request.
// Config channel (cfg_*): always ready; write gains and the P-only mode
// only while no request is in flight.
//
// A word held in the input register is decoded and applied when it advances,
// and the result is registered with the state; m_tvalid is high from then on.
// Throughput: one word per cycle while the receiver keeps up; the only loop
// is the state update (counter, target, error, duties).
// A stalled receiver holds the result and the state; the input register
// then takes one more word and s_tready drops until m_tready returns.
// Reset clears position, target, last error, duties, decoder phase and
// loads the gains with 4 and 13; both streams come up empty.

module quadrature_pd_position_servo (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] encoder_ab, [33:2] new_target, [39:34] zero
    input  wire logic [39:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] forward_duty, [15:8] reverse_duty, [47:16] position
    output logic [47:0]      m_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // Input register.
    logic                                   in_valid_reg;
    logic [1:0]                             in_type_reg;
    logic [1:0]                             in_ab_reg;
    logic signed [qpps_pkg::TARGET_W-1:0]   in_target_reg;

    // Servo state; the duty and position registers double as the result.
    logic [1:0]                             phase_reg, phase_next;
    logic signed [qpps_pkg::POS_WIDTH-1:0]  pos_reg, pos_next;
    logic signed [qpps_pkg::TARGET_W-1:0]   target_reg, target_next;
    logic signed [qpps_pkg::ERR_W-1:0]      prev_err_reg, prev_err_next;
    logic [qpps_pkg::DUTY_W-1:0]            fwd_duty_reg, fwd_duty_next;
    logic [qpps_pkg::DUTY_W-1:0]            rev_duty_reg, rev_duty_next;
    logic                                   out_valid_reg;

    // Config registers.
    logic [qpps_pkg::GAIN_W-1:0]            prop_gain_reg;
    logic [qpps_pkg::GAIN_W-1:0]            deriv_gain_reg;
    logic                                   prop_only_reg;

    logic                                   advance;
    logic signed [qpps_pkg::ERR_W-1:0]      err;
    qpps_pkg::quad_step_t                   step;
    qpps_pkg::duty_t                        law_duty;

    // Advance the held word when the result slot is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {qpps_pkg::OUT_POS_W'(pos_reg), rev_duty_reg, fwd_duty_reg};

    qpps_quad_dec u_dec (
        .phase (phase_reg),
        .ab    (in_ab_reg),
        .step  (step)
    );

    // Error against the current position, wide enough not to wrap.
    assign err = qpps_pkg::ERR_W'(target_reg) - qpps_pkg::ERR_W'(pos_reg);

    qpps_pd_law u_law (
        .err       (err),
        .prev_err  (prev_err_reg),
        .kp        (prop_gain_reg),
        .kd        (deriv_gain_reg),
        .prop_only (prop_only_reg),
        .duty      (law_duty)
    );

    // Apply the held request to the servo state.
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        target_next   = target_reg;
        prev_err_next = prev_err_reg;
        fwd_duty_next = fwd_duty_reg;
        rev_duty_next = rev_duty_reg;
        unique case (qpps_pkg::req_type_t'(in_type_reg))
            qpps_pkg::REQ_ENCODER:
            begin
                phase_next = step.phase;
                // Position is the negated count.
                if (step.cnt_up)
                    pos_next = pos_reg - qpps_pkg::POS_WIDTH'(1);
                else if (step.cnt_down)
                    pos_next = pos_reg + qpps_pkg::POS_WIDTH'(1);
            end
            qpps_pkg::REQ_TICK:
            begin
                fwd_duty_next = law_duty.fwd;
                rev_duty_next = law_duty.rev;
                if (!prop_only_reg)
                    prev_err_next = err;
            end
            qpps_pkg::REQ_TARGET:
            begin
                target_next = in_target_reg;
            end
            default:
            begin
                pos_next      = '0;
                target_next   = '0;
                fwd_duty_next = '0;
                rev_duty_next = '0;
            end
        endcase
    end

    // Hold the incoming word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg   <= s_tuser;
            in_ab_reg     <= s_tdata[1:0];
            in_target_reg <= s_tdata[33:2];
        end
    end

    // Servo state and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            pos_reg       <= '0;
            target_reg    <= '0;
            prev_err_reg  <= '0;
            fwd_duty_reg  <= '0;
            rev_duty_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                target_reg   <= target_next;
                prev_err_reg <= prev_err_next;
                fwd_duty_reg <= fwd_duty_next;
                rev_duty_reg <= rev_duty_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Config writes; unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= qpps_pkg::PROP_GAIN_RST;
            deriv_gain_reg <= qpps_pkg::DERIV_GAIN_RST;
            prop_only_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qpps_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                qpps_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                qpps_pkg::CFG_PROP_ONLY:  prop_only_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Never drive both directions at once.
    a_duty_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((fwd_duty_reg != '0) && (rev_duty_reg != '0)))
        else $error("forward and reverse duty both active");

    // Without an advance the state and result stay put.
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(pos_reg) && $stable(target_reg) && $stable(fwd_duty_reg)
                      && $stable(rev_duty_reg) && $stable(prev_err_reg)))
        else $error("servo state changed without an advancing word");

    // A clear request zeroes position, target and duties.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_type_reg == qpps_pkg::REQ_CLEAR)) |=>
            ((pos_reg == '0) && (target_reg == '0) && (fwd_duty_reg == '0)
             && (rev_duty_reg == '0)))
        else $error("clear request left state behind");

    // Decoder phase moves only on encoder requests.
    a_phase_only_on_encoder: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && (in_type_reg == qpps_pkg::REQ_ENCODER)) |=> $stable(phase_reg))
        else $error("decoder phase moved on a non-encoder word");

endmodule

`default_nettype wire

/* rtl/core/qpps_quad_dec.sv */
`default_nettype none

module qpps_quad_dec (
    input  wire logic [1:0]             phase,
    input  wire logic [1:0]             ab,
    output qpps_pkg::quad_step_t        step
);

    // Sequence 0->1->3->2->0 counts down, the reverse counts up.
    // Diagonal jumps and unchanged pins leave everything alone.
    always_comb
    begin
        step.phase    = phase;
        step.cnt_up   = 1'b0;
        step.cnt_down = 1'b0;
        unique case (phase)
            2'd0:
            begin
                if (ab == 2'd1)
                begin
                    step.phase = 2'd1; step.cnt_down = 1'b1;
                end
                else if (ab == 2'd2)
                begin
                    step.phase = 2'd2; step.cnt_up = 1'b1;
                end
            end
            2'd1:
            begin
                if (ab == 2'd0)
                begin
                    step.phase = 2'd0; step.cnt_up = 1'b1;
                end
                else if (ab == 2'd3)
                begin
                    step.phase = 2'd3; step.cnt_down = 1'b1;
                end
            end
            2'd2:
            begin
                if (ab == 2'd0)
                begin
                    step.phase = 2'd0; step.cnt_down = 1'b1;
                end
                else if (ab == 2'd3)
                begin
                    step.phase = 2'd3; step.cnt_up = 1'b1;
                end
            end
            default:
            begin
                if (ab == 2'd2)
                begin
                    step.phase = 2'd2; step.cnt_down = 1'b1;
                end
                else if (ab == 2'd1)
                begin
                    step.phase = 2'd1; step.cnt_up = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/qpps_pd_law.sv */
`default_nettype none

module qpps_pd_law (
    input  wire logic signed [qpps_pkg::ERR_W-1:0]  err,
    input  wire logic signed [qpps_pkg::ERR_W-1:0]  prev_err,
    input  wire logic [qpps_pkg::GAIN_W-1:0]        kp,
    input  wire logic [qpps_pkg::GAIN_W-1:0]        kd,
    input  wire logic                               prop_only,
    output qpps_pkg::duty_t                         duty
);

    logic signed [qpps_pkg::DERR_W-1:0]  derr;
    logic signed [qpps_pkg::PTERM_W-1:0] p_term;
    logic signed [qpps_pkg::DTERM_W-1:0] d_term;
    logic signed [qpps_pkg::RESP_W-1:0]  resp;
    logic signed [qpps_pkg::RESP_W-1:0]  lim_pos;
    logic signed [qpps_pkg::RESP_W-1:0]  lim_neg;

    assign derr   = qpps_pkg::DERR_W'(err) - qpps_pkg::DERR_W'(prev_err);
    assign p_term = qpps_pkg::PTERM_W'($signed({1'b0, kp})) * qpps_pkg::PTERM_W'(err);
    assign d_term = qpps_pkg::DTERM_W'($signed({1'b0, kd})) * qpps_pkg::DTERM_W'(derr);

    assign lim_pos = qpps_pkg::RESP_W'(qpps_pkg::DUTY_MAX);
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (prop_only)
            resp = qpps_pkg::RESP_W'(p_term);
        else
            resp = qpps_pkg::RESP_W'(p_term) + qpps_pkg::RESP_W'(d_term);

        // Clamp to full duty, then split by sign.
        if (resp > lim_pos)
        begin
            duty.fwd = qpps_pkg::DUTY_W'(qpps_pkg::DUTY_MAX);
            duty.rev = '0;
        end
        else if (resp < lim_neg)
        begin
            duty.fwd = '0;
            duty.rev = qpps_pkg::DUTY_W'(qpps_pkg::DUTY_MAX);
        end
        else if (resp > 0)
        begin
            duty.fwd = resp[qpps_pkg::DUTY_W-1:0];
            duty.rev = '0;
        end
        else
        begin
            duty.fwd = '0;
            duty.rev = qpps_pkg::DUTY_W'(-resp);
        end
    end

endmodule

`default_nettype wire

/* verif/quadrature_pd_position_servo_test.sv */
`timescale 1ns / 1ps

module quadrature_pd_position_servo_test;

    import qpps_pkg::*;

    localparam int SETTLE_CYCLES  = 4;     // result is registered when the word leaves the input register
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any channel
    localparam int PHASE_ITEMS    = 300;
    localparam int PHASE_COUNT    = 6;

    // Result word as it sits on m_tdata: position on top, forward duty at the bottom.
    typedef struct packed {
        logic [31:0] position;
        logic [7:0]  rev;
        logic [7:0]  fwd;
    } servo_word_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    // One line of the directed table: either a request word or a register write.
    typedef struct packed {
        row_kind_t   row;
        cfg_index_t  reg_index;
        logic [7:0]  reg_value;
        req_type_t   req;
        logic [1:0]  ab;
        logic [31:0] target;
        logic        typed;      // use the word below instead of the predictor
        servo_word_t want;
    } stim_row_t;

    localparam servo_word_t ZERO_WORD = '0;
    localparam servo_word_t FWD_MAX   = '{32'd0, 8'd0, 8'd255};
    localparam servo_word_t REV_MAX   = '{32'd0, 8'd255, 8'd0};
    localparam int          DIR_ROWS  = 34;

    localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // after reset: unchanged pins, then a tick at zero error
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd0, 32'd0, 1'b1, ZERO_WORD},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b1, ZERO_WORD},
        // one full cycle counting down, so position climbs to four
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd1, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd3, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd2, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd0, 32'd0, 1'b0, '0},
        // jump across the diagonal from phase zero: ignored; then a step up to phase two
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd3, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd2, 32'd0, 1'b0, '0},
        // jump across the diagonal from phase two, then unchanged pins
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd1, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd2, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd3, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_CLEAR,   2'd3, 32'hFFFF_FFFF, 1'b1, ZERO_WORD},
        // counter wraps below zero, comes back, then position wraps negative
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd2, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_ENCODER, 2'd3, 32'd0, 1'b0, '0},
        // last error survives the clear
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_CLEAR,   2'd0, 32'd0, 1'b1, ZERO_WORD},
        // target extremes drive both duties to full scale
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TARGET,  2'd0, 32'h7FFF_FFFF, 1'b1, ZERO_WORD},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b1, FWD_MAX},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TARGET,  2'd0, 32'h8000_0000, 1'b1, FWD_MAX},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b1, REV_MAX},
        // proportional-only with the widest gain
        '{ROW_CFG,  CFG_PROP_ONLY,  8'd1,   REQ_TICK, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG,  CFG_PROP_GAIN,  8'd255, REQ_TICK, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG,  CFG_DERIV_GAIN, 8'd0,   REQ_TICK, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b1, REV_MAX},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TARGET,  2'd0, 32'd3, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TARGET,  2'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b1, ZERO_WORD},
        // derivative term alone, last error frozen since the full-scale tick
        '{ROW_CFG,  CFG_PROP_GAIN,  8'd0,   REQ_TICK, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG,  CFG_DERIV_GAIN, 8'd255, REQ_TICK, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_CFG,  CFG_PROP_ONLY,  8'd0,   REQ_TICK, 2'd0, 32'd0, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TARGET,  2'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WORD, CFG_PROP_GAIN, 8'd0, REQ_TICK,    2'd0, 32'd0, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [1:0] encoder_ab, [33:2] new_target, [39:34] zero
    logic [1:0]  s_tuser = '0;     // [1:0] req_type

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [7:0] forward_duty, [15:8] reverse_duty, [47:16] position

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_PROP_GAIN;
    logic [7:0]  cfg_data = '0;

    // Mirror of the servo state, advanced on every accepted request word.
    logic [1:0]           srv_phase;
    logic [POS_WIDTH-1:0] srv_count;
    longint               srv_target;
    longint               srv_prev_err;
    logic [7:0]           srv_fwd;
    logic [7:0]           srv_rev;
    logic [7:0]           gain_p;
    logic [7:0]           gain_d;
    logic                 p_only;

    servo_word_t expected_words [$];

    int send_idle_pct = 10;
    int recv_idle_pct = 45;
    int fail_count    = 0;
    int stall_cycles  = 0;

    quadrature_pd_position_servo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Position is the negated counter, read back as a signed value of the counter width.
    function automatic longint servo_position();
        logic signed [POS_WIDTH-1:0] neg;
        neg = -srv_count;
        return longint'(neg);
    endfunction

    // Apply one request to the mirrored state and return the word it should produce.
    function automatic servo_word_t servo_apply(req_type_t kind, logic [1:0] ab,
                                                logic [31:0] tgt);
        longint      err;
        longint      resp;
        longint      pos;
        servo_word_t word;
        case (kind)
            REQ_ENCODER:
            begin
                // up: 0-2-3-1-0, down: 0-1-3-2-0; diagonal jumps and no change fall through
                case ({srv_phase, ab})
                    4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00:
                    begin
                        srv_phase = ab;
                        srv_count = srv_count + POS_WIDTH'(1);
                    end
                    4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00:
                    begin
                        srv_phase = ab;
                        srv_count = srv_count - POS_WIDTH'(1);
                    end
                    default: ;
                endcase
            end
            REQ_TICK:
            begin
                err = srv_target - servo_position();
                if (p_only)
                begin
                    resp = longint'(gain_p) * err;
                end
                else
                begin
                    resp = longint'(gain_p) * err + longint'(gain_d) * (err - srv_prev_err);
                    srv_prev_err = err;
                end
                if (resp > longint'(DUTY_MAX))
                    resp = longint'(DUTY_MAX);
                if (resp < -longint'(DUTY_MAX))
                    resp = -longint'(DUTY_MAX);
                srv_fwd = (resp > 0) ? 8'(resp) : 8'd0;
                srv_rev = (resp < 0) ? 8'(-resp) : 8'd0;
            end
            REQ_TARGET:
            begin
                srv_target = longint'($signed(tgt));
            end
            default:
            begin
                srv_count  = '0;
                srv_target = 0;
                srv_fwd    = '0;
                srv_rev    = '0;
            end
        endcase
        pos = servo_position();
        word.position = pos[31:0];
        word.rev      = srv_rev;
        word.fwd      = srv_fwd;
        return word;
    endfunction

    // Offer one request word, idling first at the current sender rate.
    // Hold tvalid high across back-to-back words; drop it only for a gap.
    task automatic send_request(input req_type_t kind, input logic [1:0] ab,
                                input logic [31:0] tgt, input logic typed,
                                input servo_word_t typed_word);
        servo_word_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, tgt, ab};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = servo_apply(kind, ab, tgt);
        expected_words.push_back(typed ? typed_word : predicted);
    endtask

    // Drop the request stream and wait until every result word is back.
    task automatic drain_servo();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PROP_GAIN:  gain_p = val;
            CFG_DERIV_GAIN: gain_d = val;
            CFG_PROP_ONLY:  p_only = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: drop tready at the current stall rate, redrawn every cycle.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every accepted result word against the oldest expectation.
    always @(posedge clk)
    begin
        servo_word_t got;
        servo_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = servo_word_t'(m_tdata);
            if (expected_words.size() == 0)
            begin
                $display("%0t ns: result word with nothing expected: fwd %0d rev %0d pos %0d",
                         $time, got.fwd, got.rev, $signed(got.position));
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    $display("%0t ns: expected fwd %0d rev %0d pos %0d, got fwd %0d rev %0d pos %0d",
                             $time, want.fwd, want.rev, $signed(want.position),
                             got.fwd, got.rev, $signed(got.position));
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no channel has moved a word for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        req_type_t   kind;
        logic [1:0]  ab;
        logic [31:0] tgt;
        int          pick;
        int          sel;
        bit          walk_up;
        longint      pos_now;

        srv_phase    = '0;
        srv_count    = '0;
        srv_target   = 0;
        srv_prev_err = 0;
        srv_fwd      = '0;
        srv_rev      = '0;
        gain_p       = PROP_GAIN_RST;
        gain_d       = DERIV_GAIN_RST;
        p_only       = 1'b0;
        walk_up      = 1'b0;

        // Hold reset, then release it on a clock edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; drain before each register write.
        foreach (DIRECTED_ROWS[i])
        begin
            if (DIRECTED_ROWS[i].row == ROW_CFG)
            begin
                drain_servo();
                write_reg(DIRECTED_ROWS[i].reg_index, DIRECTED_ROWS[i].reg_value);
            end
            else
            begin
                send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].ab,
                             DIRECTED_ROWS[i].target, DIRECTED_ROWS[i].typed,
                             DIRECTED_ROWS[i].want);
            end
        end

        // Random phases: each one gets its own gains; pairs of phases share an idle pattern.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain_servo();
            if (ph < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 45;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:
                begin
                    write_reg(CFG_PROP_GAIN, 8'd0);
                    write_reg(CFG_DERIV_GAIN, 8'd0);
                    write_reg(CFG_PROP_ONLY, 8'd0);
                end
                1:
                begin
                    write_reg(CFG_PROP_GAIN, 8'd255);
                    write_reg(CFG_DERIV_GAIN, 8'd255);
                    write_reg(CFG_PROP_ONLY, 8'd0);
                end
                2:
                begin
                    write_reg(CFG_PROP_GAIN, 8'($urandom_range(8, 1)));
                    write_reg(CFG_DERIV_GAIN, 8'($urandom_range(20, 0)));
                    write_reg(CFG_PROP_ONLY, 8'd1);
                end
                3:
                begin
                    write_reg(CFG_PROP_GAIN, 8'd1);
                    write_reg(CFG_DERIV_GAIN, 8'd255);
                    write_reg(CFG_PROP_ONLY, 8'd1);
                end
                4:
                begin
                    write_reg(CFG_PROP_GAIN, 8'($urandom_range(6, 1)));
                    write_reg(CFG_DERIV_GAIN, 8'($urandom_range(16, 0)));
                    write_reg(CFG_PROP_ONLY, 8'd0);
                end
                default:
                begin
                    write_reg(CFG_PROP_GAIN, 8'($urandom));
                    write_reg(CFG_DERIV_GAIN, 8'($urandom));
                    write_reg(CFG_PROP_ONLY, 8'($urandom_range(1, 0)));
                end
            endcase

            repeat (PHASE_ITEMS)
            begin
                // Unused fields still carry random bits.
                ab   = 2'($urandom);
                tgt  = $urandom;
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    // Mostly legal steps in runs of one direction, some stays and jumps.
                    kind = REQ_ENCODER;
                    if ($urandom_range(9) == 0)
                        walk_up = ~walk_up;
                    sel = $urandom_range(9);
                    if (sel < 7)
                    begin
                        case (srv_phase)
                            2'd0:    ab = walk_up ? 2'd2 : 2'd1;
                            2'd1:    ab = walk_up ? 2'd0 : 2'd3;
                            2'd2:    ab = walk_up ? 2'd3 : 2'd0;
                            default: ab = walk_up ? 2'd1 : 2'd2;
                        endcase
                    end
                    else if (sel < 8)
                        ab = srv_phase;
                    else
                        ab = srv_phase ^ 2'd3;
                end
                else if (pick < 85)
                    kind = REQ_TICK;
                else if (pick < 95)
                begin
                    // Keep most targets near the shaft, within 40 counts either side of the position.
                    kind = REQ_TARGET;
                    if ($urandom_range(3) != 0)
                    begin
                        pos_now = servo_position();
                        tgt = 32'(pos_now + longint'($urandom_range(80)) - 40);
                    end
                end
                else
                    kind = REQ_CLEAR;
                send_request(kind, ab, tgt, 1'b0, '0);
            end
        end

        drain_servo();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
